FILE: hdl/bole_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

    localparam int LIST_CAPACITY_DEF = 16;

    typedef logic signed [31:0] t_word;

    localparam logic [3:0] OP_INS_FRONT = 4'd0;
    localparam logic [3:0] OP_INS_BACK  = 4'd1;
    localparam logic [3:0] OP_INS_AT    = 4'd2;
    localparam logic [3:0] OP_DEL_FRONT = 4'd3;
    localparam logic [3:0] OP_DEL_BACK  = 4'd4;
    localparam logic [3:0] OP_DEL_AT    = 4'd5;
    localparam logic [3:0] OP_SEARCH    = 4'd6;
    localparam logic [3:0] OP_REVERSE   = 4'd7;
    localparam logic [3:0] OP_READ_AT   = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [3:0] opcode;
        logic [4:0] position;
        t_word      value_in;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] found_position;
        t_word      read_value;
        logic [4:0] list_length;
        t_word      max_value;
        t_word      min_value;
    } t_res;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: hdl/bole_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bole_cell import bole_pkg::*; #(
    parameter int LIST_CAPACITY = LIST_CAPACITY_DEF,
    parameter int CELL_INDEX    = 0
) (
    input  wire logic                               i_clk,
    input  wire t_cell_ctrl                         i_ctrl,
    input  wire logic [$clog2(LIST_CAPACITY)-1:0]   i_limit,
    input  wire t_word                              i_bus,
    input  wire t_word                              i_right,
    output t_word                                   o_value
);

    localparam int IW = $clog2(LIST_CAPACITY);

    logic [IW-1:0] w_index;
    t_word         r_value;
    t_word         n_value;

    assign w_index = IW'(CELL_INDEX);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift && (w_index < i_limit)) begin
            n_value = i_right;
        end else if (i_ctrl.load && (w_index == i_limit)) begin
            n_value = i_bus;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

FILE: hdl/bounded_ordered_list_engine.sv
// Ordered list of up to LIST_CAPACITY signed 32-bit entries, one command per beat.
// Input channel: i_in_valid / o_in_stall carry a t_cmd beat (opcode, position,
// value_in). Output channel: o_out_valid / i_out_stall carry one t_res beat per
// command, in command order.
// The entries sit in a chain of cells that rotates the list past the head cell;
// the head is the only tap, so every command works in a sweep of single steps.
// Steps per command, with n entries before it: inserts n+1, deletes, searches and
// reads n, reverse n-1; an empty, full or invalid-position case, a reverse of at
// most one entry and an unknown opcode take no step. After the accepting edge the
// steps run in S_RUN, then S_HOLD loads the output register once it is free.
// One command is in work at a time; o_in_stall is low only while no command is in
// work; a finished beat in the output register does not hold off the next command.
// While i_out_stall is high the output beat holds; a second finished result
// waits in the working registers and the input channel stays stalled.
// Reset (i_rst_n low, synchronous) empties the list and drops any output beat;
// cell contents are not cleared and are never read before written.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_engine import bole_pkg::*; #(
    parameter int LIST_CAPACITY = LIST_CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_cmd i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_res      o_out_data
);

    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int IW = $clog2(LIST_CAPACITY);
    localparam int PW = (CW > 5) ? CW : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    t_res          r_out, n_out;

    logic [3:0]    r_op, n_op;
    logic [4:0]    r_pos, n_pos;
    t_word         r_val, n_val;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_k, n_k;
    logic [2:0]    r_status, n_status;
    logic [4:0]    r_fpos, n_fpos;
    t_word         r_rval, n_rval;
    t_word         r_max, n_max;
    t_word         r_min, n_min;
    logic          r_any, n_any;
    logic          r_found, n_found;

    t_word         w_cell [LIST_CAPACITY];
    t_word         w_head;
    t_word         w_bus;
    t_cell_ctrl    w_ctrl;
    logic [IW-1:0] w_limit;

    logic          w_accept;
    logic          w_out_free;
    logic          w_is_ins;
    logic          w_is_del;
    logic          w_hit;
    logic          w_pos_ok;
    logic          w_empty;
    logic          w_full;
    logic          w_do_push;
    logic          w_do_drop;
    logic          w_do_rot;
    t_word         w_acc_in;
    logic          w_acc_en;

    assign w_head     = w_cell[0];
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count >= CW'(LIST_CAPACITY));
    assign w_pos_ok   = (i_in_data.position != 5'd0)
                        && (PW'(i_in_data.position) <= PW'(r_count));
    assign w_is_ins   = (r_op == OP_INS_FRONT) || (r_op == OP_INS_BACK)
                        || (r_op == OP_INS_AT);
    assign w_is_del   = (r_op == OP_DEL_FRONT) || (r_op == OP_DEL_BACK)
                        || (r_op == OP_DEL_AT);
    assign w_hit      = (r_k == r_idx);

    assign w_do_push  = (r_state == S_RUN) && (r_op != OP_REVERSE) && w_hit && w_is_ins;
    assign w_do_drop  = (r_state == S_RUN) && (r_op != OP_REVERSE) && w_hit && w_is_del;
    assign w_do_rot   = (r_state == S_RUN) && !w_do_push && !w_do_drop;

    // Drive the chain for one step of the sweep.
    always_comb begin
        w_ctrl  = '0;
        w_limit = IW'(r_count - CW'(1));
        w_bus   = w_head;
        if (r_state == S_RUN) begin
            if (r_op == OP_REVERSE) begin
                w_ctrl.shift = 1'b1;
                w_ctrl.load  = 1'b1;
                w_limit      = IW'(r_count - CW'(1) - r_k);
            end else if (w_do_push) begin
                w_ctrl.load  = 1'b1;
                w_limit      = IW'(r_count);
                w_bus        = r_val;
            end else if (w_do_drop) begin
                w_ctrl.shift = 1'b1;
            end else begin
                w_ctrl.shift = 1'b1;
                w_ctrl.load  = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
        t_word w_right;
        if (g == LIST_CAPACITY - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_mid
            assign w_right = w_cell[g + 1];
        end
        bole_cell #(
            .LIST_CAPACITY (LIST_CAPACITY),
            .CELL_INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_limit (w_limit),
            .i_bus   (w_bus),
            .i_right (w_right),
            .o_value (w_cell[g])
        );
    end

    assign w_acc_in = w_do_push ? r_val : w_head;
    assign w_acc_en = (w_is_ins || w_is_del) && (r_op != OP_REVERSE) && !w_do_drop
                      && (r_state == S_RUN);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_idx       = r_idx;
        n_total     = r_total;
        n_k         = r_k;
        n_status    = r_status;
        n_fpos      = r_fpos;
        n_rval      = r_rval;
        n_max       = r_max;
        n_min       = r_min;
        n_any       = r_any;
        n_found     = r_found;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_in_data.opcode;
                    n_pos    = i_in_data.position;
                    n_val    = i_in_data.value_in;
                    n_k      = '0;
                    n_any    = 1'b0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_fpos   = 5'd0;
                    n_rval   = '0;
                    n_idx    = '0;
                    n_total  = r_count;
                    n_state  = S_HOLD;
                    case (i_in_data.opcode)
                        OP_INS_FRONT, OP_INS_BACK: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = (i_in_data.opcode == OP_INS_BACK) ? r_count : '0;
                                n_total = r_count + CW'(1);
                                n_state = S_RUN;
                            end
                        end
                        OP_INS_AT: begin
                            if (!w_pos_ok) begin
                                n_status = ST_BADPOS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = CW'(i_in_data.position) - CW'(1);
                                n_total = r_count + CW'(1);
                                n_state = S_RUN;
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = (i_in_data.opcode == OP_DEL_BACK)
                                          ? (r_count - CW'(1)) : '0;
                                n_state = S_RUN;
                            end
                        end
                        OP_DEL_AT, OP_READ_AT: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else if (!w_pos_ok) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_idx   = CW'(i_in_data.position) - CW'(1);
                                n_state = S_RUN;
                            end
                        end
                        OP_SEARCH: begin
                            n_status = ST_NOTFOUND;
                            if (!w_empty) begin
                                n_state = S_RUN;
                            end
                        end
                        OP_REVERSE: begin
                            if (r_count > CW'(1)) begin
                                n_total = r_count - CW'(1);
                                n_state = S_RUN;
                            end
                        end
                        default: begin
                            n_state = S_HOLD;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (w_do_push) begin
                    n_count = r_count + CW'(1);
                end
                if (w_do_drop) begin
                    n_count = r_count - CW'(1);
                    n_rval  = w_head;
                end
                if (w_acc_en) begin
                    n_any = 1'b1;
                    if (!r_any || (w_acc_in > r_max)) begin
                        n_max = w_acc_in;
                    end
                    if (!r_any || (w_acc_in < r_min)) begin
                        n_min = w_acc_in;
                    end
                end
                if (w_do_rot && (r_op == OP_SEARCH) && !r_found && (w_head == r_val)) begin
                    n_found  = 1'b1;
                    n_status = ST_OK;
                    n_fpos   = 5'(r_k + CW'(1));
                    n_rval   = r_val;
                end
                if (w_do_rot && (r_op == OP_READ_AT) && w_hit) begin
                    n_fpos = r_pos;
                    n_rval = w_head;
                end
                n_k = r_k + CW'(1);
                if (r_k == r_total - CW'(1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_out_valid              = 1'b1;
                    n_out.status             = r_status;
                    n_out.found_position     = r_fpos;
                    n_out.read_value         = r_rval;
                    n_out.list_length        = 5'(r_count);
                    n_out.max_value          = w_empty ? '0 : r_max;
                    n_out.min_value          = w_empty ? '0 : r_min;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_total  <= n_total;
        r_k      <= n_k;
        r_status <= n_status;
        r_fpos   <= n_fpos;
        r_rval   <= n_rval;
        r_max    <= n_max;
        r_min    <= n_min;
        r_any    <= n_any;
        r_found  <= n_found;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input accepted while a command is still in work");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k < r_total))
        else $error("sweep step beyond its command length");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_CAPACITY))
        else $error("entry count above capacity");

    a_count_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |=> $stable(r_count))
        else $error("entry count changed outside a sweep");

endmodule

`default_nettype wire

FILE: verif/bounded_ordered_list_engine_tb.sv
`timescale 1ns / 1ps

module bounded_ordered_list_engine_tb;
    import bole_pkg::*;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 300;
    localparam int LONG_HOLD_AT   = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_cmd in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_res out_data;

    t_cmd  cmd_queue[$];
    t_res  pending_results[$];
    t_word list_q[$];

    int  plan_len = 0;
    int  mismatches = 0;
    int  cmds_accepted = 0;
    int  idle_cycles = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    bit  calm = 1'b0;
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;

    bounded_ordered_list_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void add_cmd(logic [3:0] op, logic [4:0] pos, t_word val);
        t_cmd c;
        bit   pos_ok;
        c.opcode   = op;
        c.position = pos;
        c.value_in = val;
        cmd_queue.push_back(c);
        pos_ok = (pos >= 1) && (pos <= plan_len);
        case (op)
            OP_INS_FRONT, OP_INS_BACK: if (plan_len < LIST_CAPACITY_DEF) plan_len++;
            OP_INS_AT: if (pos_ok && plan_len < LIST_CAPACITY_DEF) plan_len++;
            OP_DEL_FRONT, OP_DEL_BACK: if (plan_len > 0) plan_len--;
            OP_DEL_AT: if (pos_ok) plan_len--;
            default: ;
        endcase
    endfunction

    function automatic t_res apply_list_cmd(t_cmd c);
        t_res  r;
        int    n;
        int    idx;
        bit    pos_ok;
        t_word tmp;
        r      = '0;
        n      = list_q.size();
        idx    = int'(c.position) - 1;
        pos_ok = (c.position >= 1) && (c.position <= n);
        case (c.opcode)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (n >= LIST_CAPACITY_DEF) r.status = ST_FULL;
                else if (c.opcode == OP_INS_FRONT) list_q.push_front(c.value_in);
                else list_q.push_back(c.value_in);
            end
            OP_INS_AT: begin
                if (!pos_ok) r.status = ST_BADPOS;
                else if (n >= LIST_CAPACITY_DEF) r.status = ST_FULL;
                else list_q.insert(idx, c.value_in);
            end
            OP_DEL_FRONT: begin
                if (n == 0) r.status = ST_EMPTY;
                else r.read_value = list_q.pop_front();
            end
            OP_DEL_BACK: begin
                if (n == 0) r.status = ST_EMPTY;
                else r.read_value = list_q.pop_back();
            end
            OP_DEL_AT: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (!pos_ok) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.read_value = list_q[idx];
                    list_q.delete(idx);
                end
            end
            OP_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (list_q[i] == c.value_in) begin
                        r.status         = ST_OK;
                        r.found_position = 5'(i + 1);
                        r.read_value     = c.value_in;
                        break;
                    end
                end
            end
            OP_REVERSE: begin
                for (int i = 0; i < n / 2; i++) begin
                    tmp            = list_q[i];
                    list_q[i]      = list_q[n - 1 - i];
                    list_q[n - 1 - i] = tmp;
                end
            end
            OP_READ_AT: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (!pos_ok) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.found_position = c.position;
                    r.read_value     = list_q[idx];
                end
            end
            default: ;
        endcase
        r.list_length = 5'(list_q.size());
        if (list_q.size() > 0) begin
            r.max_value = list_q[0];
            r.min_value = list_q[0];
            foreach (list_q[i]) begin
                if (list_q[i] > r.max_value) r.max_value = list_q[i];
                if (list_q[i] < r.min_value) r.min_value = list_q[i];
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s expected %0h actual %0h", name, want, got);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                in_data  <= cmd_queue.pop_front();
                in_valid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!long_hold_done && cmds_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 99) < 3) begin
            hold_left = $urandom_range(8, 40);
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge clk) begin : monitor
        t_res want;
        bit   busy;
        if (!rst_n) begin
            in_taken  = 1'b0;
            out_taken = 1'b0;
        end else begin
            in_taken  = in_valid && !in_stall;
            out_taken = out_valid && !out_stall;
            if (in_taken) begin
                pending_results.push_back(apply_list_cmd(in_data));
                cmds_accepted++;
            end
            if (out_taken) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $error("result beat with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("found_position", 32'(want.found_position),
                                32'(out_data.found_position));
                    check_field("read_value", want.read_value, out_data.read_value);
                    check_field("list_length", 32'(want.list_length),
                                32'(out_data.list_length));
                    check_field("max_value", want.max_value, out_data.max_value);
                    check_field("min_value", want.min_value, out_data.min_value);
                end
            end
            cycle_count++;
            if (cycle_count % 200 == 0) calm = ($urandom_range(0, 3) == 0);
            busy = (cmd_queue.size() > 0) || in_valid || (pending_results.size() > 0);
            if (in_taken || out_taken || !busy) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int         ins_pct;
        int         r;
        t_word      pool [8];
        logic [3:0] op;
        logic [4:0] pos;
        t_word      val;

        // empty list corners
        add_cmd(OP_REVERSE, 5'd0, 32'sd0);
        add_cmd(OP_SEARCH, 5'd0, 32'sd5);
        add_cmd(OP_DEL_FRONT, 5'd0, 32'sd0);
        add_cmd(OP_DEL_BACK, 5'd0, 32'sd0);
        add_cmd(OP_DEL_AT, 5'd1, 32'sd0);
        add_cmd(OP_READ_AT, 5'd1, 32'sd0);
        add_cmd(OP_INS_AT, 5'd1, 32'sd9);
        // insert extremes
        add_cmd(OP_INS_FRONT, 5'd0, 32'sh7FFF_FFFF);
        add_cmd(OP_INS_BACK, 5'd0, 32'sh8000_0000);
        add_cmd(OP_INS_AT, 5'd1, -32'sd1);
        add_cmd(OP_INS_AT, 5'd2, 32'sd0);
        add_cmd(OP_INS_BACK, 5'd0, 32'sd5);
        // reads, searches, bad positions, reverse, deletes and an invalid opcode
        add_cmd(OP_READ_AT, 5'd0, 32'sd0);
        add_cmd(OP_READ_AT, 5'd31, 32'sd0);
        add_cmd(OP_READ_AT, 5'd3, 32'sd0);
        add_cmd(OP_SEARCH, 5'd0, 32'sd5);
        add_cmd(OP_SEARCH, 5'd0, 32'sd6);
        add_cmd(OP_REVERSE, 5'd0, 32'sd0);
        add_cmd(OP_READ_AT, 5'd1, 32'sd0);
        add_cmd(OP_DEL_AT, 5'd0, 32'sd0);
        add_cmd(OP_DEL_AT, 5'd6, 32'sd0);
        add_cmd(OP_DEL_AT, 5'd2, 32'sd0);
        add_cmd(OP_DEL_FRONT, 5'd0, 32'sd0);
        add_cmd(OP_DEL_BACK, 5'd0, 32'sd0);
        add_cmd(4'd15, 5'd16, 32'sd1);

        ins_pct = 50;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 120 == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 85;
                    1: ins_pct = 50;
                    default: ins_pct = 20;
                endcase
                foreach (pool[j]) pool[j] = $urandom;
            end
            r = $urandom_range(0, 99);
            if (r < ins_pct) op = 4'($urandom_range(0, 2));
            else if ($urandom_range(0, 2) != 0) op = 4'($urandom_range(3, 5));
            else op = 4'($urandom_range(6, 8));
            if ($urandom_range(0, 99) < 3) op = 4'($urandom_range(9, 15));

            if ($urandom_range(0, 9) == 0) pos = 5'($urandom_range(0, 31));
            else if (plan_len > 0) pos = 5'($urandom_range(1, plan_len));
            else pos = 5'd1;

            r = $urandom_range(0, 99);
            if (r < ((op == OP_SEARCH) ? 70 : 40)) begin
                val = pool[$urandom_range(0, 7)];
            end else if (r < 45) begin
                case ($urandom_range(0, 3))
                    0: val = 32'sh7FFF_FFFF;
                    1: val = 32'sh8000_0000;
                    2: val = 32'sd0;
                    default: val = -32'sd1;
                endcase
            end else begin
                val = $urandom;
            end
            add_cmd(op, pos, val);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
